// ===== src/scsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SATA command slot manager package
// Widths, codes, request and result types shared by the slot manager files.
// ----------------------------------------------------------------------------
package scsm_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int SLOT_W     = 5;
  localparam int TIME_W     = 48;
  localparam int TICK_W     = 32;
  localparam int MASK_W     = 32;
  localparam int CMD_W      = 2;
  localparam int OPCODE_W   = 8;
  localparam int KIND_W     = 2;
  localparam int CODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_ISSUE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd2;

  localparam logic [OPCODE_W-1:0] OPC_FPDMA_READ  = 8'h60;
  localparam logic [OPCODE_W-1:0] OPC_FPDMA_WRITE = 8'h61;

  localparam logic [KIND_W-1:0] KIND_ISSUE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SWEEP_END = 2'd3;

  localparam logic [CODE_W-1:0] CODE_OK      = 2'd0;
  localparam logic [CODE_W-1:0] CODE_STALL   = 2'd1;
  localparam logic [CODE_W-1:0] CODE_NO_SLOT = 2'd2;
  localparam logic [CODE_W-1:0] CODE_TIMEOUT = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TAG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [SLOT_W-1:0] MAX_TAG_RESET = 5'd31;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1000000;
  localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    OP_ISSUE  = 2'd0,
    OP_UPDATE = 2'd1,
    OP_SWEEP  = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              ncq;
    logic [MASK_W-1:0] hw_mask;
    logic [TIME_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] code;
    logic              set_active;
    logic              unaccounted;
    logic              still_active;
    logic              last;
  } res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic [SLOT_W-1:0] max_tag;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

endpackage

// ===== src/scsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== src/scsm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot manager front end
// Takes requests, drops unused commands and classifies the opcode.
// ----------------------------------------------------------------------------
module scsm_front (
  input  logic                           start,
  input  scsm_pkg::q_stat_t              q_stat,
  input  logic [scsm_pkg::CMD_W-1:0]     cmd,
  input  logic [scsm_pkg::OPCODE_W-1:0]  opcode,
  input  logic [scsm_pkg::MASK_W-1:0]    hw_mask,
  input  logic [scsm_pkg::TIME_W-1:0]    now_time,
  output logic                           push,
  output scsm_pkg::req_t                 req
);
  import scsm_pkg::*;

  logic known;

  always_comb begin
    known  = 1'b1;
    req.op = OP_ISSUE;
    case (cmd)
      CMD_ISSUE:  req.op = OP_ISSUE;
      CMD_UPDATE: req.op = OP_UPDATE;
      CMD_SWEEP:  req.op = OP_SWEEP;
      default:    known  = 1'b0;
    endcase
    req.ncq      = (opcode == OPC_FPDMA_READ) || (opcode == OPC_FPDMA_WRITE);
    req.hw_mask  = hw_mask;
    req.now_time = now_time;
    push         = start && !q_stat.full && known;
  end

endmodule

// ===== src/scsm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot manager request queue
// Short queue of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module scsm_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  scsm_pkg::req_t               push_req,
  input  logic                         pop,
  output scsm_pkg::req_t               head,
  output scsm_pkg::q_stat_t            q_stat,
  output logic [scsm_pkg::QCNT_W-1:0]  count
);
  import scsm_pkg::*;

  req_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign count        = count_r;

endmodule

// ===== src/scsm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot manager back end
// Carries out issue, status update and sweep requests and drives results.
// ----------------------------------------------------------------------------
module scsm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  scsm_pkg::cfg_t     cfg,
  input  scsm_pkg::q_stat_t  q_stat,
  input  scsm_pkg::req_t     head,
  output logic               pop,
  output logic               res_valid,
  output scsm_pkg::res_t     res
);
  import scsm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_END   = 4'b1000
  } state_t;

  localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(SLOT_COUNT - 1);

  state_t                  state_r, state_nxt;
  req_t                    cur_r, cur_nxt;
  logic [SLOT_COUNT-1:0]   running_r, running_nxt;
  logic [SLOT_COUNT-1:0]   completed_r, completed_nxt;
  logic                    paused_r, paused_nxt;
  logic [SLOT_IDX_W-1:0]   idx_r, idx_nxt;
  logic                    pending_r, pending_nxt;
  logic                    valid_r, valid_nxt;
  res_t                    res_r, res_nxt;

  logic                    ram_we;
  logic [SLOT_IDX_W-1:0]   ram_waddr;
  logic [TIME_W-1:0]       ram_wdata;
  logic [SLOT_IDX_W-1:0]   ram_raddr;
  logic [TIME_W-1:0]       ram_rdata;

  logic [SLOT_COUNT-1:0]   hw_slots;
  logic [SLOT_COUNT-1:0]   busy_slots;
  logic [SLOT_COUNT-1:0]   avail;
  logic                    found;
  logic [SLOT_IDX_W-1:0]   found_idx;
  logic [TIME_W:0]         dl_sum;
  logic [TIME_W-1:0]       deadline;
  logic                    run_any;

  scsm_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SLOT_COUNT)
  ) u_deadline_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    hw_slots   = cur_r.hw_mask[SLOT_COUNT-1:0];
    busy_slots = hw_slots | running_r | completed_r;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      avail[i] = !busy_slots[i] && (SLOT_W'(i) <= cfg.max_tag);
    end
    found     = 1'b0;
    found_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found     = 1'b1;
        found_idx = SLOT_IDX_W'(i);
      end
    end
    dl_sum   = {1'b0, cur_r.now_time} + (TIME_W + 1)'(cfg.timeout_ticks);
    deadline = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
    run_any  = |running_r;
  end

  assign ram_raddr = ((state_r == ST_SWEEP) && (idx_r != LAST_IDX)) ?
                     idx_r + SLOT_IDX_W'(1) : '0;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    running_nxt   = running_r;
    completed_nxt = completed_r;
    paused_nxt    = paused_r;
    idx_nxt       = idx_r;
    pending_nxt   = pending_r;
    valid_nxt     = 1'b0;
    res_nxt       = res_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = deadline;

    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          cur_nxt   = head;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_nxt      = '0;
        res_nxt.last = 1'b1;
        state_nxt    = ST_IDLE;
        case (cur_r.op)
          OP_ISSUE: begin
            valid_nxt    = 1'b1;
            res_nxt.kind = KIND_ISSUE;
            if (paused_r && run_any) begin
              res_nxt.code = CODE_STALL;
            end else begin
              paused_nxt = !cur_r.ncq;
              if (!cur_r.ncq && run_any) begin
                res_nxt.code = CODE_STALL;
              end else if ((!cur_r.ncq && busy_slots[0]) || (cur_r.ncq && !found)) begin
                res_nxt.code = CODE_NO_SLOT;
              end else begin
                ram_we             = 1'b1;
                ram_waddr          = cur_r.ncq ? found_idx : '0;
                running_nxt        = running_r | (SLOT_COUNT'(1) << ram_waddr);
                res_nxt.slot       = SLOT_W'(ram_waddr);
                res_nxt.code       = CODE_OK;
                res_nxt.set_active = cur_r.ncq;
              end
            end
          end
          OP_UPDATE: begin
            valid_nxt           = 1'b1;
            res_nxt.kind        = KIND_UPDATE;
            res_nxt.unaccounted = |(hw_slots & ~running_r & ~completed_r);
            completed_nxt       = completed_r | (running_r & ~hw_slots);
          end
          OP_SWEEP: begin
            idx_nxt     = '0;
            pending_nxt = 1'b0;
            state_nxt   = ST_SWEEP;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SWEEP: begin
        if (running_r[idx_r]) begin
          if (completed_r[idx_r] || (ram_rdata <= cur_r.now_time)) begin
            valid_nxt              = 1'b1;
            res_nxt                = '0;
            res_nxt.kind           = KIND_DONE;
            res_nxt.slot           = SLOT_W'(idx_r);
            res_nxt.code           = completed_r[idx_r] ? CODE_OK : CODE_TIMEOUT;
            running_nxt[idx_r]     = 1'b0;
            completed_nxt[idx_r]   = 1'b0;
          end else begin
            pending_nxt = 1'b1;
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_END;
        end else begin
          idx_nxt = idx_r + SLOT_IDX_W'(1);
        end
      end
      ST_END: begin
        valid_nxt            = 1'b1;
        res_nxt              = '0;
        res_nxt.kind         = KIND_SWEEP_END;
        res_nxt.still_active = pending_r;
        res_nxt.last         = 1'b1;
        if (!run_any) begin
          paused_nxt = 1'b0;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      running_r   <= '0;
      completed_r <= '0;
      paused_r    <= 1'b0;
      idx_r       <= '0;
      pending_r   <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      completed_r <= completed_nxt;
      paused_r    <= paused_nxt;
      idx_r       <= idx_nxt;
      pending_r   <= pending_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    res_r <= res_nxt;
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

// ===== src/sata_command_slot_manager_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SATA command slot manager
// Tracks queued command slots of one SATA port: issue, status update, sweep.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Requests
// wait in a two-entry queue, so busy rises only when two requests are queued
// behind the one at work; unused commands are taken and dropped.
// Each result is shown for one cycle with out_valid high and out_last marks
// the final result of a request. The receiver cannot hold results off.
// An issue or status update request is taken from the queue in ST_IDLE and
// evaluated in ST_EXEC; its single result is then registered and shown.
// A sweep visits every slot in turn, one slot a cycle, reading each deadline
// from the slot deadline RAM; finished slots are reported as they are found
// and the sweep end result follows.
// Reset clears the slot masks, the pause flag and the queue, and loads the
// default max_tag and timeout; deadlines are written when a slot is issued.
// Configuration is written through cfg_we, cfg_index and cfg_wdata.
// ----------------------------------------------------------------------------
module sata_command_slot_manager_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [scsm_pkg::CMD_W-1:0]       in_cmd,
  input  logic [scsm_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [scsm_pkg::MASK_W-1:0]      in_hw_mask,
  input  logic [scsm_pkg::TIME_W-1:0]      in_now_time,
  output logic                             out_valid,
  output logic [scsm_pkg::KIND_W-1:0]      out_kind,
  output logic [scsm_pkg::SLOT_W-1:0]      out_slot,
  output logic [scsm_pkg::CODE_W-1:0]      out_code,
  output logic                             out_set_active,
  output logic                             out_unaccounted,
  output logic                             out_still_active,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [scsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import scsm_pkg::*;

  logic [SLOT_W-1:0] max_tag_r, max_tag_nxt;
  logic [TICK_W-1:0] timeout_r, timeout_nxt;
  cfg_t              cfg;
  q_stat_t           q_stat;
  req_t              push_req;
  req_t              head;
  logic              push;
  logic              pop;
  logic [QCNT_W-1:0] q_count;
  res_t              res;

  always_comb begin
    max_tag_nxt = max_tag_r;
    timeout_nxt = timeout_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_TAG: max_tag_nxt = cfg_wdata[SLOT_W-1:0];
        CFG_TIMEOUT: timeout_nxt = cfg_wdata[TICK_W-1:0];
        default: begin
          max_tag_nxt = max_tag_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tag_r <= MAX_TAG_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      max_tag_r <= max_tag_nxt;
      timeout_r <= timeout_nxt;
    end
  end

  assign cfg.max_tag       = max_tag_r;
  assign cfg.timeout_ticks = timeout_r;

  scsm_front u_front (
    .start    (start),
    .q_stat   (q_stat),
    .cmd      (in_cmd),
    .opcode   (in_opcode),
    .hw_mask  (in_hw_mask),
    .now_time (in_now_time),
    .push     (push),
    .req      (push_req)
  );

  scsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat),
    .count    (q_count)
  );

  scsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign busy             = q_stat.full;
  assign out_kind         = res.kind;
  assign out_slot         = res.slot;
  assign out_code         = res.code;
  assign out_set_active   = res.set_active;
  assign out_unaccounted  = res.unaccounted;
  assign out_still_active = res.still_active;
  assign out_last         = res.last;

`ifndef SYNTHESIS
  a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (q_count != '0))
    else $error("queued request lost");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_sweep_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_SWEEP_END)) |-> out_last)
    else $error("sweep end without last mark");

  a_done_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_DONE)) |=> (out_valid && !out_last) || !out_valid ||
      (out_kind == KIND_DONE) || (out_kind == KIND_SWEEP_END))
    else $error("finished slot not followed by sweep results");
`endif

endmodule
